// ===== sv/lbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants of the 5x5 line-buffer convolution
// Holds the fixed weight and bias tables and the widths of the datapath.
// ----------------------------------------------------------------------------
package lbc_pkg;

	localparam int PIX_W      = 8;
	localparam int WGT_W      = 9;
	localparam int OUT_CH     = 6;
	localparam int ROM_TAPS   = 5;
	localparam int CH_W       = 8;
	localparam int BIAS_W     = 32;
	// one product and the sum of one window row (at most eight taps)
	localparam int PROD_W     = PIX_W + WGT_W;
	localparam int ROWSUM_W   = PROD_W + 3;

	typedef logic signed [PIX_W-1:0]    pix_t;
	typedef logic signed [WGT_W-1:0]    wgt_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ROWSUM_W-1:0] rowsum_t;
	typedef logic [CH_W-1:0]            chan_t;

	// weight[c][i][j] = trunc(256*sin(c*i*j))
	localparam wgt_t WEIGHT_ROM [OUT_CH][ROM_TAPS][ROM_TAPS] = '{
		'{ '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0} },
		'{ '{0,0,0,0,0}, '{0,215,232,36,-193}, '{0,232,-193,-71,253},
		   '{0,36,-71,105,-137}, '{0,-193,253,-137,-73} },
		'{ '{0,0,0,0,0}, '{0,232,-193,-71,253}, '{0,-193,253,-137,-73},
		   '{0,-71,-137,-192,-231}, '{0,253,-73,-231,141} },
		'{ '{0,0,0,0,0}, '{0,36,-71,105,-137}, '{0,-71,-137,-192,-231},
		   '{0,105,-192,244,-253}, '{0,-137,-231,-253,-196} },
		'{ '{0,0,0,0,0}, '{0,-193,253,-137,-73}, '{0,253,-73,-231,141},
		   '{0,-137,-231,-253,-196}, '{0,-73,141,-196,235} },
		'{ '{0,0,0,0,0}, '{0,-245,-139,166,233}, '{0,-139,233,-252,190},
		   '{0,166,-252,217,-78}, '{0,233,190,-78,-254} }
	};

	// bias[c] = trunc(65536*sin(c))
	localparam logic signed [BIAS_W-1:0] BIAS_ROM [OUT_CH] = '{
		32'sd0, 32'sd55146, 32'sd59591, 32'sd9248, -32'sd49597, -32'sd62844
	};

	// Taps outside the 5x5 table weigh zero.
	function automatic wgt_t tap_weight(input int c, input int i, input int j);
		wgt_t w;
		w = '0;
		if (i < ROM_TAPS && j < ROM_TAPS) begin
			w = WEIGHT_ROM[c][i][j];
		end
		return w;
	endfunction

endpackage

// ===== sv/lbc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_in_if: pixel channel
// Valid/ready handshake carrying one signed pixel per scan position.
// ----------------------------------------------------------------------------
interface lbc_in_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

// ===== sv/lbc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_out_if: result channel
// Valid/ready handshake carrying the six ReLU channel bytes.
// ----------------------------------------------------------------------------
interface lbc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] channel_0;
	logic [7:0] channel_1;
	logic [7:0] channel_2;
	logic [7:0] channel_3;
	logic [7:0] channel_4;
	logic [7:0] channel_5;

	modport source (output valid, output channel_0, output channel_1, output channel_2,
		output channel_3, output channel_4, output channel_5, input ready);
	modport sink   (input valid, input channel_0, input channel_1, input channel_2,
		input channel_3, input channel_4, input channel_5, output ready);
endinterface

// ===== sv/lbc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 36
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/lbc_window.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_window: scan counters, line store and sliding window
// Each accepted item shifts one column into the window; the line store keeps
// the last KERNEL_SIZE-1 pixels of every scan column in a RAM word.
// ----------------------------------------------------------------------------
module lbc_window
	import lbc_pkg::*;
#(
	parameter int IMAGE_WIDTH  = 32,
	parameter int IMAGE_HEIGHT = 32,
	parameter int KERNEL_SIZE  = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	lbc_in_if.sink    pixels,
	input  logic      mac_ready,
	output logic      win_valid,
	output pix_t      win [KERNEL_SIZE][KERNEL_SIZE]
);

	localparam int SCAN_W = IMAGE_WIDTH + KERNEL_SIZE - 1;
	localparam int SCAN_H = IMAGE_HEIGHT + KERNEL_SIZE - 1;
	localparam int CW     = $clog2(SCAN_W);
	localparam int RW     = $clog2(SCAN_H);
	localparam int LW     = (KERNEL_SIZE - 1) * PIX_W;

	logic [CW-1:0] col_q, col_nxt;
	logic [RW-1:0] row_q, row_nxt;
	logic          accept;
	logic          in_image;
	logic          produce;
	pix_t          pix;
	logic [LW-1:0] line_rd, line_wr;
	logic [CW-1:0] rd_addr;
	pix_t          new_col [KERNEL_SIZE];
	pix_t          win_q [KERNEL_SIZE][KERNEL_SIZE];
	logic          valid_q;

	// the window may take a new column unless it still holds an unread result
	assign pixels.ready = !valid_q || mac_ready;
	assign accept       = pixels.valid && pixels.ready;

	// padding positions feed zero
	assign in_image = (row_q < RW'(IMAGE_HEIGHT)) && (col_q < CW'(IMAGE_WIDTH));
	assign pix      = in_image ? pixels.pixel : '0;
	assign produce  = (row_q >= RW'(KERNEL_SIZE - 1)) && (col_q >= CW'(KERNEL_SIZE - 1));

	// advance the raster position
	always_comb begin
		col_nxt = col_q + CW'(1);
		row_nxt = row_q;
		if (col_q == CW'(SCAN_W - 1)) begin
			col_nxt = '0;
			row_nxt = (row_q == RW'(SCAN_H - 1)) ? '0 : row_q + RW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (accept) begin
				col_q   <= col_nxt;
				row_q   <= row_nxt;
				valid_q <= produce;
			end else if (mac_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// read one column ahead so the word is ready when its item arrives
	assign rd_addr = accept ? col_nxt : col_q;

	// new column: stored rows move up, the pixel enters at the bottom
	always_comb begin
		for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
			new_col[i] = line_rd[i*PIX_W +: PIX_W];
		end
		new_col[KERNEL_SIZE-1] = pix;
		for (int m = 0; m < KERNEL_SIZE - 1; m++) begin
			line_wr[m*PIX_W +: PIX_W] = new_col[m+1];
		end
	end

	lbc_ram #(
		.WIDTH (LW),
		.DEPTH (SCAN_W)
	) u_line (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (line_wr),
		.raddr (rd_addr),
		.rdata (line_rd)
	);

	// shift the window left by one column
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
					win_q[i][j] <= win_q[i][j+1];
				end
				win_q[i][KERNEL_SIZE-1] <= new_col[i];
			end
		end
	end

	assign win_valid = valid_q;
	assign win       = win_q;

endmodule

// ===== sv/lbc_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbc_mac: six-channel multiply-accumulate with ReLU
// First stage sums the constant-weight products of each window row; second
// stage adds the row sums and the bias, applies ReLU and holds the result.
// ----------------------------------------------------------------------------
module lbc_mac
	import lbc_pkg::*;
#(
	parameter int KERNEL_SIZE = 5,
	parameter int ACC_WIDTH   = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      win_valid,
	input  pix_t      win [KERNEL_SIZE][KERNEL_SIZE],
	output logic      mac_ready,
	lbc_out_if.source results
);

	rowsum_t                rs_comb [OUT_CH][KERNEL_SIZE];
	rowsum_t                rs_s2   [OUT_CH][KERNEL_SIZE];
	logic                   valid_s2;
	logic                   en_s2;
	logic                   en_out;
	logic [ACC_WIDTH-1:0]   acc     [OUT_CH];
	chan_t                  ch_comb [OUT_CH];
	chan_t                  ch_q    [OUT_CH];
	logic                   out_valid_q;
	prod_t                  prod;

	assign en_out    = !out_valid_q || results.ready;
	assign en_s2     = !valid_s2 || en_out;
	assign mac_ready = en_s2;

	// row sums of the window products
	always_comb begin
		prod = '0;
		for (int c = 0; c < OUT_CH; c++) begin
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				rs_comb[c][i] = '0;
				for (int j = 0; j < KERNEL_SIZE; j++) begin
					prod = PROD_W'(win[i][j]) * PROD_W'(tap_weight(c, i, j));
					rs_comb[c][i] = rs_comb[c][i] + ROWSUM_W'(prod);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && win_valid) begin
			rs_s2 <= rs_comb;
		end
	end

	// bias plus row sums, wrapping, then ReLU on the sign bit
	always_comb begin
		for (int c = 0; c < OUT_CH; c++) begin
			acc[c] = ACC_WIDTH'(BIAS_ROM[c]);
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				acc[c] = acc[c] + ACC_WIDTH'(rs_s2[c][i]);
			end
			ch_comb[c] = acc[c][ACC_WIDTH-1] ? '0 : acc[c][CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			ch_q <= ch_comb;
		end
	end

	// hold valid flags while the downstream stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= win_valid;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	assign results.valid     = out_valid_q;
	assign results.channel_0 = ch_q[0];
	assign results.channel_1 = ch_q[1];
	assign results.channel_2 = ch_q[2];
	assign results.channel_3 = ch_q[3];
	assign results.channel_4 = ch_q[4];
	assign results.channel_5 = ch_q[5];

endmodule

// ===== sv/line_buffer_conv5x5_relu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_buffer_conv5x5_relu: streaming 5x5 convolution, six channels, ReLU
// Walks a zero-padded raster, keeps a line store and a sliding window, and
// emits one six-channel item per position once the window is full.
// ----------------------------------------------------------------------------
//  channel   dir  payload                      role
//  pixels    in   pixel (s8)                   one scan position per item
//  results   out  channel_0..channel_5 (u8)    ReLU low bytes, one per full window
//
//  One item per cycle sustained while results is not stalled; a result is registered
//  in the window register, the row-sum register and the result register, in order.
//  The line store RAM is read one column ahead, so its registered read does not
//  delay the result. Reset clears the raster position and the valid flags only.
//  A stall on results backs up through the stages; pixels keep flowing until
//  every stage holding a result is full.
// ----------------------------------------------------------------------------
module line_buffer_conv5x5_relu
	import lbc_pkg::*;
#(
	parameter int IMAGE_WIDTH  = 32,
	parameter int IMAGE_HEIGHT = 32,
	parameter int KERNEL_SIZE  = 5,
	parameter int ACC_WIDTH    = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	lbc_in_if.sink    pixels,
	lbc_out_if.source results
);

	logic win_valid;
	logic mac_ready;
	pix_t win [KERNEL_SIZE][KERNEL_SIZE];

	lbc_window #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT),
		.KERNEL_SIZE  (KERNEL_SIZE)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pixels),
		.mac_ready (mac_ready),
		.win_valid (win_valid),
		.win       (win)
	);

	lbc_mac #(
		.KERNEL_SIZE (KERNEL_SIZE),
		.ACC_WIDTH   (ACC_WIDTH)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (win_valid),
		.win       (win),
		.mac_ready (mac_ready),
		.results   (results)
	);

	// an empty result register never blocks the pixel side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!results.valid |-> pixels.ready)
		else $error("pixels stalled with empty result register");

	// a full window waiting on the MAC blocks new pixels
	a_window_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid && !mac_ready |-> !pixels.ready)
		else $error("window overwritten while its result waits");

	// a waiting window result is kept
	a_window_held: assert property (@(posedge clk) disable iff (!arst_n)
		win_valid && !mac_ready |=> win_valid)
		else $error("window result dropped during stall");

endmodule

// ===== bench/conv_relu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv_relu_checker: result checker for the 5x5 line-buffer convolution
// Watches the pixel and result channels and keeps its own line store, window
// and raster position. It works out the six ReLU bytes of every position that
// completes a window and compares each result, in order, with the oldest one.
// ----------------------------------------------------------------------------
module conv_relu_checker
	import lbc_pkg::*;
#(
	parameter int IMAGE_WIDTH  = 32,
	parameter int IMAGE_HEIGHT = 32,
	parameter int KERNEL_SIZE  = 5,
	parameter int ACC_WIDTH    = 32
) (
	input  logic clk,
	input  logic arst_n,
	lbc_in_if    pixels,
	lbc_out_if   results,
	output int   errors,
	output int   pending,
	output int   results_checked
);

	localparam int SCAN_W     = IMAGE_WIDTH + KERNEL_SIZE - 1;
	localparam int SCAN_H     = IMAGE_HEIGHT + KERNEL_SIZE - 1;
	localparam int TABLE_TAPS = 5;

	// trunc(256*sin(c*i*j)), indexed [channel][row][column]
	localparam int CONV_WEIGHT [OUT_CH][TABLE_TAPS][TABLE_TAPS] = '{
		'{ '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0}, '{0,0,0,0,0} },
		'{ '{0,0,0,0,0}, '{0,215,232,36,-193}, '{0,232,-193,-71,253},
		   '{0,36,-71,105,-137}, '{0,-193,253,-137,-73} },
		'{ '{0,0,0,0,0}, '{0,232,-193,-71,253}, '{0,-193,253,-137,-73},
		   '{0,-71,-137,-192,-231}, '{0,253,-73,-231,141} },
		'{ '{0,0,0,0,0}, '{0,36,-71,105,-137}, '{0,-71,-137,-192,-231},
		   '{0,105,-192,244,-253}, '{0,-137,-231,-253,-196} },
		'{ '{0,0,0,0,0}, '{0,-193,253,-137,-73}, '{0,253,-73,-231,141},
		   '{0,-137,-231,-253,-196}, '{0,-73,141,-196,235} },
		'{ '{0,0,0,0,0}, '{0,-245,-139,166,233}, '{0,-139,233,-252,190},
		   '{0,166,-252,217,-78}, '{0,233,190,-78,-254} }
	};

	// trunc(65536*sin(c))
	localparam int CONV_BIAS [OUT_CH] = '{0, 55146, 59591, 9248, -49597, -62844};

	typedef chan_t [OUT_CH-1:0] relu_bytes_t;

	pix_t        line_rows [KERNEL_SIZE][SCAN_W];
	pix_t        win [KERNEL_SIZE][KERNEL_SIZE];
	int          scan_r;
	int          scan_c;
	relu_bytes_t expected_relu [$];

	// Sum one channel over the current window, wrap, and apply ReLU.
	function automatic chan_t relu_channel(input int c);
		logic [ACC_WIDTH-1:0] acc;
		int prod;
		acc = ACC_WIDTH'(CONV_BIAS[c]);
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE; j++) begin
				// taps beyond the table weigh zero
				if (i < TABLE_TAPS && j < TABLE_TAPS) begin
					prod = int'(win[i][j]) * CONV_WEIGHT[c][i][j];
					acc = acc + ACC_WIDTH'(prod);
				end
			end
		end
		return acc[ACC_WIDTH-1] ? chan_t'(0) : acc[CH_W-1:0];
	endfunction

	// Advance the raster by one accepted item; queue a result once the window is full.
	task automatic take_pixel(input pix_t raw);
		pix_t        v;
		relu_bytes_t r;
		v = (scan_r < IMAGE_HEIGHT && scan_c < IMAGE_WIDTH) ? raw : pix_t'(0);
		for (int i = 0; i < KERNEL_SIZE - 1; i++) begin
			line_rows[i][scan_c] = line_rows[i+1][scan_c];
		end
		line_rows[KERNEL_SIZE-1][scan_c] = v;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
				win[i][j] = win[i][j+1];
			end
			win[i][KERNEL_SIZE-1] = line_rows[i][scan_c];
		end
		if (scan_r >= KERNEL_SIZE - 1 && scan_c >= KERNEL_SIZE - 1) begin
			for (int c = 0; c < OUT_CH; c++) begin
				r[c] = relu_channel(c);
			end
			expected_relu.push_back(r);
		end
		scan_c++;
		if (scan_c >= SCAN_W) begin
			scan_c = 0;
			scan_r++;
			if (scan_r >= SCAN_H) begin
				scan_r = 0;
			end
		end
	endtask

	// Compare one result with the oldest expectation, channel by channel.
	task automatic check_result(input relu_bytes_t got);
		relu_bytes_t want;
		bit          bad;
		if (expected_relu.size() == 0) begin
			$display("%0t ns: result with nothing expected, got %h", $time, got);
			errors++;
		end else begin
			want = expected_relu.pop_front();
			bad = 0;
			for (int c = 0; c < OUT_CH; c++) begin
				if (got[c] !== want[c]) begin
					$display("%0t ns: result %0d channel_%0d expected %0d got %0d",
						$time, results_checked, c, want[c], got[c]);
					bad = 1;
				end
			end
			if (bad) begin
				errors++;
			end
			results_checked++;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
		results_checked = 0;
	end

	// Sample both channels at the rising edge; results first, then the new item.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_r = 0;
			scan_c = 0;
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				for (int j = 0; j < SCAN_W; j++) begin
					line_rows[i][j] = '0;
				end
				for (int j = 0; j < KERNEL_SIZE; j++) begin
					win[i][j] = '0;
				end
			end
			expected_relu.delete();
			pending = 0;
		end else begin
			if (results.valid === 1'b1 && results.ready === 1'b1) begin
				check_result({results.channel_5, results.channel_4, results.channel_3,
					results.channel_2, results.channel_1, results.channel_0});
			end
			if (pixels.valid === 1'b1 && pixels.ready === 1'b1) begin
				take_pixel(pixels.pixel);
			end
			pending = expected_relu.size();
		end
	end

endmodule

// ===== bench/line_buffer_conv5x5_relu_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_buffer_conv5x5_relu_test: stream test of the 5x5 convolution block
// Streams a short opening of extreme and single-bit pixels, then patterned random pixels
// until a little more than one full scan raster has been sent, so the frame wraps, with
// random gaps and result stalls. The checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module line_buffer_conv5x5_relu_test;
	import lbc_pkg::*;

	localparam int IMG_W      = 32;
	localparam int IMG_H      = 32;
	localparam int KSIZE      = 5;
	localparam int ACC_W      = 32;
	localparam int SCAN_W     = IMG_W + KSIZE - 1;
	localparam int SCAN_H     = IMG_H + KSIZE - 1;
	localparam int FRAME_POS  = SCAN_W * SCAN_H;
	localparam int TOTAL      = FRAME_POS + 8;
	localparam int DRAIN      = 20;

	localparam int OPENING [25] = '{
		0, -128, 127, -1, 1, 85, -86, 64, -64, 127, 127, -128, -128,
		2, -2, 4, -4, 8, -8, 16, -16, 32, -32, 126, -127
	};

	typedef enum int {PAT_UNIFORM, PAT_MAX, PAT_MIN, PAT_CHECKER, PAT_SMALL} pattern_t;

	logic clk;
	logic arst_n;
	bit   no_gaps;
	int   sent;
	int   check_errors;
	int   check_pending;
	int   check_results;

	lbc_in_if  pixels ();
	lbc_out_if results ();

	line_buffer_conv5x5_relu #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H),
		.KERNEL_SIZE (KSIZE),
		.ACC_WIDTH   (ACC_W)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.results(results)
	);

	conv_relu_checker #(
		.IMAGE_WIDTH (IMG_W),
		.IMAGE_HEIGHT(IMG_H),
		.KERNEL_SIZE (KSIZE),
		.ACC_WIDTH   (ACC_W)
	) relu_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.pixels         (pixels),
		.results        (results),
		.errors         (check_errors),
		.pending        (check_pending),
		.results_checked(check_results)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Bound the run.
	initial begin
		#400000;
		$display("line_buffer_conv5x5_relu_test: errors");
		$finish;
	end

	// Pick a row pattern: uniform noise half the time, else flat extremes for large sums, a checkerboard or small values.
	function automatic pattern_t pick_pattern();
		int r;
		r = $urandom_range(9);
		if (r < 5) begin
			return PAT_UNIFORM;
		end else if (r == 5) begin
			return PAT_MAX;
		end else if (r == 6) begin
			return PAT_MIN;
		end else if (r == 7) begin
			return PAT_CHECKER;
		end
		return PAT_SMALL;
	endfunction

	function automatic pix_t next_pixel(input pattern_t pat, input int idx);
		pix_t p;
		p = pix_t'($urandom_range(255));
		case (pat)
			PAT_MAX: begin
				if ($urandom_range(7) != 0) p = 8'sd127;
			end
			PAT_MIN: begin
				if ($urandom_range(7) != 0) p = -8'sd128;
			end
			PAT_CHECKER: begin
				p = idx[0] ? 8'sd127 : -8'sd128;
			end
			PAT_SMALL: begin
				p = pix_t'(int'($urandom_range(8)) - 4);
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	// Offer one item after a random gap, none while no_gaps is set, and hold it until it is taken.
	task automatic send_pixel(input pix_t p);
		while (!no_gaps && $urandom_range(99) < 20) begin
			pixels.valid <= 1'b0;
			pixels.pixel <= pix_t'($urandom_range(255));
			@(negedge clk);
		end
		pixels.valid <= 1'b1;
		pixels.pixel <= p;
		do @(posedge clk); while (pixels.ready !== 1'b1);
		sent++;
		@(negedge clk);
	endtask

	// Stall results at random, in short bursts now and then, never in the steady stretch.
	initial begin
		int hold;
		hold = 0;
		results.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (no_gaps) begin
				results.ready <= 1'b1;
			end else if (hold > 0) begin
				results.ready <= 1'b0;
				hold--;
			end else if ($urandom_range(99) < 3) begin
				hold = $urandom_range(12, 4);
				results.ready <= 1'b0;
			end else begin
				results.ready <= ($urandom_range(99) >= 17);
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		pattern_t pat;
		pixels.valid = 1'b0;
		pixels.pixel = '0;
		arst_n = 1'b0;
		no_gaps = 1'b0;
		sent = 0;
		pat = PAT_UNIFORM;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// opening: field extremes and single-bit values along the first row
		foreach (OPENING[k]) begin
			send_pixel(pix_t'(OPENING[k]));
		end

		// patterned random rows through a frame wrap into the next frame
		while (sent < TOTAL) begin
			if (sent % SCAN_W == 0) begin
				pat = pick_pattern();
			end
			no_gaps = (sent >= 500 && sent < 800);
			send_pixel(next_pixel(pat, sent));
		end
		pixels.valid <= 1'b0;
		no_gaps = 1'b0;

		// drain the pipeline
		wait (check_pending == 0);
		repeat (DRAIN) @(posedge clk);

		$display("summary: %0d pixels streamed over %0d scan positions per frame,",
			sent, FRAME_POS);
		$display("summary: %0d six-channel results compared, %0d still awaited",
			check_results, check_pending);
		if (check_errors == 0 && check_pending == 0) begin
			$display("line_buffer_conv5x5_relu_test: clean");
		end else begin
			$display("line_buffer_conv5x5_relu_test: errors");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lbc_pkg.sv
sv/lbc_in_if.sv
sv/lbc_out_if.sv
sv/lbc_ram.sv
sv/lbc_window.sv
sv/lbc_mac.sv
sv/line_buffer_conv5x5_relu.sv
bench/conv_relu_checker.sv
bench/line_buffer_conv5x5_relu_test.sv
